### sv/wss_pkg.sv
// Shared types and constants for the weighted slice selector.
`default_nettype none

package wss_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int MASK_W        = 8;
  localparam int SLICE_IDX_W   = 3;
  localparam int RATE_W        = 16;
  localparam int CNT_W         = 4;
  localparam int WPACK_W       = 64;
  localparam int WEIGHT_STRIDE = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;
  localparam int REG_IDX_W     = 2;
  localparam int REG_IDX_LSB   = 3;

  // Unity in the Q0.16 rate format.
  localparam logic [RATE_W:0] RATE_ONE = 17'h10000;

  // Register indexes; byte address is eight times the index.
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RATE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT   = 2'd2;

  // Register reset values.
  localparam logic [WPACK_W-1:0] WEIGHTS_RST = '0;
  localparam logic [RATE_W-1:0]  RATE_RST    = 16'd655;
  localparam logic [CNT_W-1:0]   COUNT_RST   = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load;
    logic                   scan;
    logic                   mul;
    logic                   wr;
    logic                   oload;
    logic [SLICE_IDX_W-1:0] idx;
  } wss_cmd_t;

endpackage

`default_nettype wire

### sv/wss_ifs.sv
// Valid/ready channel interfaces for the slice request and the decision.
`default_nettype none

interface wss_in_if import wss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] slice_ready_mask;

  modport source (output valid, output slice_ready_mask, input ready);
  modport sink   (input valid, input slice_ready_mask, output ready);
endinterface

interface wss_out_if import wss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SLICE_IDX_W-1:0] served_slice;
  logic                   any_ready;

  modport source (output valid, output served_slice, output any_ready, input ready);
  modport sink   (input valid, input served_slice, input any_ready, output ready);
endinterface

`default_nettype wire

### sv/wss_regs.sv
// APB-style configuration registers of the slice selector.
`default_nettype none

module wss_regs import wss_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [WPACK_W-1:0]    weights_r,
  output logic      [RATE_W-1:0]     rate_r,
  output logic      [CNT_W-1:0]      count_r
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= WEIGHTS_RST;
      rate_r    <= RATE_RST;
      count_r   <= COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WEIGHTS: weights_r <= pwdata[WPACK_W-1:0];
        REG_RATE:    rate_r    <= pwdata[RATE_W-1:0];
        REG_COUNT:   count_r   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WEIGHTS: prdata = CFG_DATA_W'(weights_r);
      REG_RATE:    prdata = CFG_DATA_W'(rate_r);
      REG_COUNT:   prdata = CFG_DATA_W'(count_r);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/wss_ctrl.sv
// Sequencing controller: scan pass, decay/update pass, result hand-off.
`default_nettype none

module wss_ctrl import wss_pkg::*; #(
  parameter int NUM_SLICES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output wss_cmd_t  cmd
);

  localparam int IW = $clog2(NUM_SLICES);
  localparam logic [IW-1:0] LAST = IW'(NUM_SLICES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UMUL = 3'd2;
  localparam logic [2:0] ST_UWR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.idx       = SLICE_IDX_W'(cnt_r);
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_UMUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UWR;
      end
      ST_UWR: begin
        cmd.wr = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_UMUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.oload     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.mul, cmd.wr, cmd.oload}))
    else $error("more than one datapath command at once");
  a_wr_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(cmd.mul))
    else $error("average write without a product in the previous cycle");
  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SCAN && cnt_r == '0))
    else $error("scan does not start at slice zero after a request");
  a_oload_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.oload |=> out_valid_r)
    else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

### sv/wss_dp.sv
// Datapath: served-share averages, ratio compare, decay and rate update.
`default_nettype none

module wss_dp import wss_pkg::*; #(
  parameter int NUM_SLICES        = 8,
  parameter int AVERAGE_FRAC_BITS = 16,
  parameter int WEIGHT_BITS       = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wss_cmd_t               cmd,
  input  wire logic [MASK_W-1:0]      slice_ready_mask,
  input  wire logic [WPACK_W-1:0]     weights,
  input  wire logic [RATE_W-1:0]      rate,
  input  wire logic [CNT_W-1:0]       count,
  output logic      [SLICE_IDX_W-1:0] served_slice_r,
  output logic                        any_ready_r
);

  localparam int IW = $clog2(NUM_SLICES);
  localparam int AW = AVERAGE_FRAC_BITS + 1;
  localparam int SW = AW + 1;
  localparam int PW = WEIGHT_BITS + AW;
  localparam int MW = AW + RATE_W + 1;

  logic [AW-1:0]          avg_r [NUM_SLICES];
  logic [NUM_SLICES-1:0]  act_r;
  logic [NUM_SLICES-1:0]  act_nxt;
  logic                   stop_r;
  logic                   any_r;
  logic [WEIGHT_BITS-1:0] best_w_r;
  logic [AW-1:0]          best_avg_r;
  logic [IW-1:0]          chosen_r;
  logic [MW-1:0]          prod_r;

  logic [WEIGHT_BITS-1:0] w_arr [NUM_SLICES];
  logic [IW-1:0]          idx;
  logic [AW-1:0]          cur_avg;
  logic [WEIGHT_BITS-1:0] cur_w;
  logic                   cur_act;
  logic [PW-1:0]          lhs;
  logic [PW-1:0]          rhs;
  logic [RATE_W:0]        factor;
  logic [AW-1:0]          decayed;
  logic [SW-1:0]          rate_fmt;
  logic [SW-1:0]          sum;
  logic [AW-1:0]          new_avg;

  always_comb begin
    for (int i = 0; i < NUM_SLICES; i++) begin
      w_arr[i]   = weights[WEIGHT_STRIDE*i +: WEIGHT_BITS];
      act_nxt[i] = slice_ready_mask[i] && (CNT_W'(i) < count);
    end
  end

  assign idx     = cmd.idx[IW-1:0];
  assign cur_avg = avg_r[idx];
  assign cur_w   = w_arr[idx];
  assign cur_act = act_r[idx];

  // Ratio test by cross-multiplication: w/a >= best_w/best_a.
  assign lhs = cur_w * best_avg_r;
  assign rhs = best_w_r * cur_avg;

  assign factor  = RATE_ONE - {1'b0, rate};
  assign decayed = prod_r[RATE_W +: AW];

  generate
    if (AVERAGE_FRAC_BITS >= RATE_W) begin : g_rate_up
      assign rate_fmt = SW'(rate) << (AVERAGE_FRAC_BITS - RATE_W);
    end else begin : g_rate_dn
      assign rate_fmt = SW'(rate >> (RATE_W - AVERAGE_FRAC_BITS));
    end
  endgenerate

  assign sum     = {1'b0, decayed} + ((idx == chosen_r) ? rate_fmt : SW'(0));
  assign new_avg = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLICES; i++) begin
        avg_r[i] <= '0;
      end
      act_r          <= '0;
      stop_r         <= 1'b0;
      any_r          <= 1'b0;
      chosen_r       <= '0;
      served_slice_r <= '0;
      any_ready_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r      <= act_nxt;
        any_r      <= |act_nxt;
        stop_r     <= 1'b0;
        best_w_r   <= '0;
        best_avg_r <= AW'(1);
        chosen_r   <= '0;
      end
      if (cmd.scan && cur_act && !stop_r) begin
        if (cur_avg == '0) begin
          chosen_r <= idx;
          stop_r   <= 1'b1;
        end else if (lhs >= rhs) begin
          best_w_r   <= cur_w;
          best_avg_r <= cur_avg;
          chosen_r   <= idx;
        end
      end
      if (cmd.mul) begin
        prod_r <= cur_avg * factor;
      end
      if (cmd.wr && cur_act) begin
        avg_r[idx] <= new_avg;
      end
      if (cmd.oload) begin
        served_slice_r <= SLICE_IDX_W'(chosen_r);
        any_ready_r    <= any_r;
      end
    end
  end

endmodule

`default_nettype wire

### sv/weighted_slice_selector_ewma.sv
// Top level of the weighted slice selector with served-share moving averages.
//
//   Channel   Direction  Handshake                 Payload
//   in_ch     sink       valid/ready               slice_ready_mask[7:0]
//   out_ch    source     valid/ready               served_slice[2:0], any_ready
//   APB cfg   slave      psel/penable, pready=1    paddr[4:0], pwdata/prdata[63:0]
//
// From acceptance to the next acceptance a request passes a load, a scan of each slice
// for the ratio compare, then a multiply and a write per slice for the average update,
// and the result hand-off; no new request is taken before it is through.
// The per-slice update through the single decay multiplier takes the largest share.
// Reset (rst_n low, synchronous) clears all averages and loads the register defaults.
// A finished result waits in the output register while the next request is taken;
// only a second finished result stalls behind an unread one.
`default_nettype none

module weighted_slice_selector_ewma import wss_pkg::*; #(
  parameter int NUM_SLICES        = 8,
  parameter int AVERAGE_FRAC_BITS = 16,
  parameter int WEIGHT_BITS       = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wss_in_if.sink                     in_ch,
  wss_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Configuration registers as seen by the datapath.
  logic [WPACK_W-1:0] weights;
  logic [RATE_W-1:0]  rate;
  logic [CNT_W-1:0]   count;

  // Command bundle from the controller.
  wss_cmd_t cmd;

  // The register block holds the weights, the update rate and the slice count. The
  // user must see they are only written while no request is in flight; not enforced.
  wss_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .weights_r (weights),
    .rate_r    (rate),
    .count_r   (count)
  );

  // The controller walks the slices twice per request: first to pick the
  // served slice, then to decay every ready slice and credit the served one.
  wss_ctrl #(
    .NUM_SLICES (NUM_SLICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath keeps the averages and the running best candidate, and
  // holds the result register that feeds the output channel.
  wss_dp #(
    .NUM_SLICES        (NUM_SLICES),
    .AVERAGE_FRAC_BITS (AVERAGE_FRAC_BITS),
    .WEIGHT_BITS       (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .slice_ready_mask (in_ch.slice_ready_mask),
    .weights          (weights),
    .rate             (rate),
    .count            (count),
    .served_slice_r   (out_ch.served_slice),
    .any_ready_r      (out_ch.any_ready)
  );

endmodule

`default_nettype wire

### verif/tb_weighted_slice_selector_ewma.sv
// Self-checking testbench for the weighted slice selector with served-share averages.
`timescale 1ns / 100ps

module tb_weighted_slice_selector_ewma;
  import wss_pkg::*;

  // The block is built with its default parameters. The bench keeps its own
  // copies so that its slice selection predictor follows the same sizes.
  localparam int NUM_SLICES        = 8;
  localparam int AVERAGE_FRAC_BITS = 16;
  localparam int WEIGHT_BITS       = 8;

  localparam int CLK_PERIOD = 10;

  // One request occupies the block for a load, a scan of each slice, a multiply
  // and a write per slice for the average update, and the result hand-off.
  localparam int REQ_CYCLES = 2 + 3 * NUM_SLICES;

  // Upper bound of the random gap that each side waits per request when idling.
  localparam int MAX_GAP = 16;

  // Length of the one long output hold-off. It is far longer than a request,
  // so the output register and the finished result behind it both fill and
  // the input has to stall.
  localparam int HOLD_CYCLES = 300;

  // In a correct run the longest quiet stretch comes from a request time plus
  // both gaps, or from the long hold-off. The limit is several times the worst
  // of those.
  localparam int WATCHDOG_LIMIT = 2000;

  // After the last decision the block is given a settling stretch to show
  // any stray decision it might still produce.
  localparam int SETTLE_CYCLES = 3 * REQ_CYCLES;

  localparam int RANDOM_PHASES    = 10;
  localparam int RANDOM_PER_PHASE = 125;

  // Register index past the end of the register list; writes there are ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint unsigned WEIGHT_MASK = (64'd1 << WEIGHT_BITS) - 1;
  localparam longint unsigned AVG_MAX     = (64'd1 << (AVERAGE_FRAC_BITS + 1)) - 1;
  localparam longint unsigned RATE_UNITY  = 64'd1 << RATE_W;

  // Expected content of one decision.
  typedef struct packed {
    logic [SLICE_IDX_W-1:0] served_slice;
    logic                   any_ready;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wss_in_if  in_if ();
  wss_out_if out_if ();

  weighted_slice_selector_ewma dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the block's registers and of its per-slice served-share averages.
  logic [WPACK_W-1:0]          cfg_weights;
  logic [RATE_W-1:0]           cfg_rate;
  logic [CNT_W-1:0]            cfg_count;
  logic [AVERAGE_FRAC_BITS:0]  share_avg [NUM_SLICES];

  // Decisions predicted for accepted requests and not yet seen at the output.
  decision_t pending_decisions [$];

  // Idling switches for the two sides, and the long hold-off request that
  // the receiver process picks up and counts down on its own.
  bit send_idle;
  bit recv_idle;
  int hold_request;

  int errors;
  int n_requests;
  int n_checked;
  int n_no_ready;
  int n_settings;
  int quiet_cycles;
  int input_stall_cycles;

  // Predicts the decision for one tick and ages the averages the way the
  // block does. Slices are scanned upward: a ready slice with a zero average
  // wins at once; otherwise the largest weight/average ratio wins, compared
  // by cross-multiplication, with the later slice taking a tie. Then every
  // ready slice decays by (1 - rate) and the served slice gains the rate.
  function automatic decision_t pick_and_age(input logic [MASK_W-1:0] mask);
    decision_t         d;
    int                active;
    bit                settled;
    longint unsigned   best_w;
    longint unsigned   best_a;
    longint unsigned   w;
    longint unsigned   a;
    longint unsigned   v;
    longint unsigned   rate_aligned;
    d       = '0;
    settled = 1'b0;
    best_w  = 0;
    best_a  = 1;
    // A programmed slice count above the build size is clipped to it.
    active  = (cfg_count < NUM_SLICES) ? int'(cfg_count) : NUM_SLICES;
    for (int i = 0; i < active; i++) begin
      if (mask[i]) begin
        d.any_ready = 1'b1;
        if (!settled) begin
          a = 64'(share_avg[i]);
          if (a == 0) begin
            d.served_slice = SLICE_IDX_W'(i);
            settled        = 1'b1;
          end else begin
            w = (cfg_weights >> (WEIGHT_STRIDE * i)) & WEIGHT_MASK;
            if (w * best_a >= best_w * a) begin
              best_w         = w;
              best_a         = a;
              d.served_slice = SLICE_IDX_W'(i);
            end
          end
        end
      end
    end
    // With nothing ready the averages stay as they are.
    if (d.any_ready) begin
      if (AVERAGE_FRAC_BITS >= RATE_W)
        rate_aligned = 64'(cfg_rate) << (AVERAGE_FRAC_BITS - RATE_W);
      else
        rate_aligned = 64'(cfg_rate) >> (RATE_W - AVERAGE_FRAC_BITS);
      for (int i = 0; i < active; i++) begin
        if (mask[i]) begin
          v = (64'(share_avg[i]) * (RATE_UNITY - 64'(cfg_rate))) >> RATE_W;
          if (SLICE_IDX_W'(i) == d.served_slice) begin
            v = v + rate_aligned;
            if (v > AVG_MAX) v = AVG_MAX;
          end
          share_avg[i] = v[AVERAGE_FRAC_BITS:0];
        end
      end
    end
    return d;
  endfunction

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return CFG_ADDR_W'(idx) << REG_IDX_LSB;
  endfunction

  // Mostly arbitrary masks, with empty, full and single-slice masks mixed in.
  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      default: return MASK_W'($urandom());
    endcase
  endfunction

  // One APB transfer: setup cycle, then access until pready. The bus is left
  // selected so that back-to-back transfers go straight from access to setup;
  // the caller releases it after the last one.
  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic check_readback(input string name, input logic [CFG_DATA_W-1:0] want,
                                input logic [CFG_DATA_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s readback mismatch: expected 0x%h, actual 0x%h",
               $time, name, want, got);
    end
  endtask

  // Writes all three registers, reads each one back, and optionally writes
  // the index past the end of the register list, which must change nothing.
  // Only called while the block is idle, so the mirror is updated at once.
  task automatic program_regs(input logic [63:0] weights, input logic [63:0] rate_word,
                              input logic [63:0] count_word, input bit poke_spare);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b1, reg_addr(REG_WEIGHTS), weights, rd);
    cfg_weights = weights;
    apb_access(1'b0, reg_addr(REG_WEIGHTS), '0, rd);
    check_readback("slice_weights_packed", cfg_weights, rd);
    apb_access(1'b1, reg_addr(REG_RATE), rate_word, rd);
    cfg_rate = rate_word[RATE_W-1:0];
    apb_access(1'b0, reg_addr(REG_RATE), '0, rd);
    check_readback("average_rate", CFG_DATA_W'(cfg_rate), rd);
    apb_access(1'b1, reg_addr(REG_COUNT), count_word, rd);
    cfg_count = count_word[CNT_W-1:0];
    apb_access(1'b0, reg_addr(REG_COUNT), '0, rd);
    check_readback("slices_in_use", CFG_DATA_W'(cfg_count), rd);
    if (poke_spare) apb_access(1'b1, reg_addr(REG_SPARE), '1, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Offers one mask request after an optional random gap and waits until it
  // is taken. The prediction is made here, at the accepting edge, so that
  // the pending store is up to date as soon as the task returns.
  task automatic send_request(input logic [MASK_W-1:0] mask);
    int        gap;
    decision_t predicted;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.slice_ready_mask <= mask;
    do @(posedge clk); while (!in_if.ready);
    predicted         = pick_and_age(mask);
    pending_decisions = {pending_decisions, predicted};
    n_requests++;
  endtask

  // Stops offering requests and waits until every predicted decision has
  // come out. Every request yields exactly one decision, so the block is
  // idle afterwards and registers may be written.
  task automatic drain_decisions();
    in_if.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  // Reset values of the three registers.
  task automatic test_register_defaults();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, reg_addr(REG_WEIGHTS), '0, rd);
    check_readback("slice_weights_packed", CFG_DATA_W'(WEIGHTS_RST), rd);
    apb_access(1'b0, reg_addr(REG_RATE), '0, rd);
    check_readback("average_rate", CFG_DATA_W'(RATE_RST), rd);
    apb_access(1'b0, reg_addr(REG_COUNT), '0, rd);
    check_readback("slices_in_use", CFG_DATA_W'(COUNT_RST), rd);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // With the reset weights of zero every ratio is zero. Starting from empty
  // averages the first ready slice wins at once; once averages are nonzero
  // every comparison is a tie and the later slice wins. Also covers the
  // empty mask, which must produce slice 0 with the ready flag low.
  task automatic test_default_weights();
    send_request(8'h00);
    send_request(8'hFF);
    send_request(8'hFF);
    send_request(8'h01);
    send_request(8'h03);
    send_request(8'h80);
  endtask

  // Distinct weights with the fastest rate make the ratio test decide, then
  // all-maximum weights with a zero rate freeze the averages. The write past
  // the end of the register list must leave the setting untouched.
  task automatic test_ratio_choice();
    drain_decisions();
    program_regs(64'h80_40_20_10_08_04_02_01, 64'd65535, 64'd8, 1'b0);
    send_request(8'hFF);
    send_request(8'hFF);
    send_request(8'h55);
    send_request(8'hAA);
    send_request(8'hFF);
    drain_decisions();
    program_regs('1, 64'd0, 64'd8, 1'b1);
    send_request(8'hFF);
    send_request(8'h0F);
  endtask

  // Slice counts of one, zero, beyond the build size and in between. Mask
  // bits at or above the count must be ignored, and a count of zero means
  // that nothing is ever ready.
  task automatic test_slice_count();
    drain_decisions();
    program_regs(64'h00_FF_10_20_00_01_80_7F, 64'd655, 64'd1, 1'b0);
    send_request(8'hFE);
    send_request(8'hFF);
    drain_decisions();
    program_regs(64'h00_FF_10_20_00_01_80_7F, 64'd655, 64'd0, 1'b0);
    send_request(8'hFF);
    drain_decisions();
    program_regs(64'h00_FF_10_20_00_01_80_7F, 64'd40000, 64'd15, 1'b0);
    send_request(8'h80);
    send_request(8'hC0);
    drain_decisions();
    program_regs(64'h00_FF_10_20_00_01_80_7F, 64'd40000, 64'd3, 1'b0);
    send_request(8'hF8);
    send_request(8'h07);
  endtask

  // The receiver holds off for a long stretch while requests are offered
  // back to back, so the block fills up and has to stall its input.
  task automatic test_output_backpressure();
    drain_decisions();
    program_regs({$urandom(), $urandom()}, 64'd655, 64'd8, 1'b0);
    send_idle    = 1'b0;
    recv_idle    = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (16) send_request(random_mask());
    drain_decisions();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Phases of random masks, each under its own register setting and its own
  // idling pattern, from both sides idling to no idling at all.
  task automatic test_random_traffic();
    logic [63:0] weights;
    logic [63:0] rate_word;
    logic [63:0] count_word;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_decisions();
      for (int b = 0; b < NUM_SLICES; b++) begin
        case ($urandom_range(0, 9))
          0, 1:    weights[WEIGHT_STRIDE*b +: WEIGHT_STRIDE] = '0;
          2:       weights[WEIGHT_STRIDE*b +: WEIGHT_STRIDE] = '1;
          default: weights[WEIGHT_STRIDE*b +: WEIGHT_STRIDE] = WEIGHT_STRIDE'($urandom());
        endcase
      end
      // Upper bits of the narrow registers are junk that must be dropped.
      rate_word  = {$urandom(), $urandom()};
      count_word = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
        0:       rate_word[RATE_W-1:0] = '0;
        1:       rate_word[RATE_W-1:0] = '1;
        2:       rate_word[RATE_W-1:0] = RATE_RST;
        3:       rate_word[RATE_W-1:0] = RATE_W'($urandom_range(1, 255));
        default: rate_word[RATE_W-1:0] = RATE_W'($urandom());
      endcase
      if ($urandom_range(0, 3) != 0)
        count_word[CNT_W-1:0] = CNT_W'(NUM_SLICES);
      else
        count_word[CNT_W-1:0] = CNT_W'($urandom_range(0, 15));
      program_regs(weights, rate_word, count_word, $urandom_range(0, 3) == 0);
      case (phase % 4)
        0:       begin send_idle = 1'b1; recv_idle = 1'b1; end
        1:       begin send_idle = 1'b0; recv_idle = 1'b1; end
        2:       begin send_idle = 1'b1; recv_idle = 1'b0; end
        default: begin send_idle = 1'b0; recv_idle = 1'b0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_mask());
    end
  endtask

  // Result receiver. After each decision it takes it may stall for a random
  // number of cycles, and it runs the long hold-off when one is requested.
  initial begin : decision_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (out_if.valid && out_if.ready)
          stall_left = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // Every decision taken is compared field by field with the oldest prediction.
  always @(posedge clk) begin : check_decisions
    decision_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: decision with no request pending: served_slice %0d any_ready %0b",
                 $time, out_if.served_slice, out_if.any_ready);
      end else begin
        want = pending_decisions.pop_front();
        n_checked++;
        if (!want.any_ready) n_no_ready++;
        if (out_if.served_slice !== want.served_slice) begin
          errors++;
          $display("%0t: served_slice mismatch: expected %0d, actual %0d",
                   $time, want.served_slice, out_if.served_slice);
        end
        if (out_if.any_ready !== want.any_ready) begin
          errors++;
          $display("%0t: any_ready mismatch: expected %0b, actual %0b",
                   $time, want.any_ready, out_if.any_ready);
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel nor the register port has
  // moved for too long. Also counts cycles in which a request was refused.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_n && in_if.valid && !in_if.ready) input_stall_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d decisions still pending",
               $time, quiet_cycles, pending_decisions.size());
      $display("[weighted_slice_selector_ewma] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_if.valid            <= 1'b0;
    in_if.slice_ready_mask <= '0;
    cfg_weights  = WEIGHTS_RST;
    cfg_rate     = RATE_RST;
    cfg_count    = COUNT_RST;
    for (int i = 0; i < NUM_SLICES; i++) share_avg[i] = '0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_request = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_default_weights();
    test_ratio_choice();
    test_slice_count();
    test_output_backpressure();
    test_random_traffic();

    // Let the block show any stray decision before the verdict.
    drain_decisions();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d mask requests, %0d decisions checked (%0d with no slice ready),",
             n_requests, n_checked, n_no_ready);
    $display("Summary: %0d register settings, one %0d-cycle output hold-off, %0d input stalls.",
             n_settings, HOLD_CYCLES, input_stall_cycles);
    if (errors == 0) begin
      $display("[weighted_slice_selector_ewma] OK");
    end else begin
      $display("[weighted_slice_selector_ewma] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/wss_pkg.sv
sv/wss_ifs.sv
sv/wss_regs.sv
sv/wss_ctrl.sv
sv/wss_dp.sv
sv/weighted_slice_selector_ewma.sv
verif/tb_weighted_slice_selector_ewma.sv
